// File: sv/nbpl_pkg.sv
`timescale 1ns / 1ps

package nbpl_pkg;

   // Default sizes of the stores and of the value datapath.
   localparam int DEF_MAX_BASE     = 256;
   localparam int DEF_MAX_FEATURES = 16;
   localparam int DEF_MAX_OUT_DIMS = 4;
   localparam int DEF_VALUE_WIDTH  = 32;

   // Fixed widths of the external value fields and of the distance accumulator.
   localparam int DATA_WIDTH = 32;
   localparam int DIST_WIDTH = 64;

   // Operation codes carried by an input transfer.
   typedef enum logic [1:0] {
      OP_BASE_FEATURE = 2'd0,
      OP_BASE_PROJ    = 2'd1,
      OP_QUERY        = 2'd2
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_READ,
      S_SHOW
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic feat_wr;
      logic proj_wr;
      logic query_wr;
      logic scan_clear;
      logic issue;
      logic issue_first;
      logic issue_last;
      logic proj_rd;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
   } status_type;

endpackage

// File: sv/nbpl_ctrl.sv
`timescale 1ns / 1ps

module nbpl_ctrl #(
   parameter int MAX_BASE     = nbpl_pkg::DEF_MAX_BASE,
   parameter int MAX_FEATURES = nbpl_pkg::DEF_MAX_FEATURES,
   parameter int MAX_OUT_DIMS = nbpl_pkg::DEF_MAX_OUT_DIMS,
   localparam int BW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1,
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
   localparam int DW = (MAX_OUT_DIMS > 1) ? $clog2(MAX_OUT_DIMS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [7:0]           req_entry,
   input  logic [3:0]           req_element,
   input  logic                 req_last,
   input  logic [8:0]           base_count,
   input  logic [4:0]           feature_count,
   input  logic [2:0]           out_dims,
   output nbpl_pkg::cmd_type    cmd,
   input  nbpl_pkg::status_type status,
   output logic [BW-1:0]        scan_base,
   output logic [FW-1:0]        scan_feat,
   output logic [DW-1:0]        emit_dim,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_coord_index,
   output logic                 rsp_last_result
);
   import nbpl_pkg::*;

   state_type     state_ff, state_in;
   logic [BW-1:0] base_ff, base_in;
   logic [FW-1:0] feat_ff, feat_in;
   logic [DW-1:0] dim_ff, dim_in;

   logic [12:0] nb_eff, nb_last;
   logic [6:0]  nf_eff, nf_last;
   logic [3:0]  nd_eff, nd_last;
   logic        base_last_hit, feat_last_hit, dim_last_hit;
   logic        entry_ok, feat_elem_ok, proj_elem_ok;
   logic [31:0] dim_wide;
   op_type      op;

   // Effective register values: zero acts as one, values above the store size clamp to it.
   always_comb begin
      if (base_count == 9'd0) begin
         nb_eff = 13'd1;
      end else if (13'(base_count) > 13'(MAX_BASE)) begin
         nb_eff = 13'(MAX_BASE);
      end else begin
         nb_eff = 13'(base_count);
      end
      if (feature_count == 5'd0) begin
         nf_eff = 7'd1;
      end else if (7'(feature_count) > 7'(MAX_FEATURES)) begin
         nf_eff = 7'(MAX_FEATURES);
      end else begin
         nf_eff = 7'(feature_count);
      end
      if (out_dims == 3'd0) begin
         nd_eff = 4'd1;
      end else if (4'(out_dims) > 4'(MAX_OUT_DIMS)) begin
         nd_eff = 4'(MAX_OUT_DIMS);
      end else begin
         nd_eff = 4'(out_dims);
      end
   end

   assign nb_last = nb_eff - 13'd1;
   assign nf_last = nf_eff - 7'd1;
   assign nd_last = nd_eff - 4'd1;

   assign base_last_hit = (base_ff == nb_last[BW-1:0]);
   assign feat_last_hit = (feat_ff == nf_last[FW-1:0]);
   assign dim_last_hit  = (dim_ff == nd_last[DW-1:0]);

   // Writes outside the stores are dropped.
   assign entry_ok     = ({24'd0, req_entry} < 32'(MAX_BASE));
   assign feat_elem_ok = ({28'd0, req_element} < 32'(MAX_FEATURES));
   assign proj_elem_ok = ({28'd0, req_element} < 32'(MAX_OUT_DIMS));
   assign op           = op_type'(req_operation);

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= '0;
         feat_ff  <= '0;
         dim_ff   <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         feat_ff  <= feat_in;
         dim_ff   <= dim_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      feat_in   = feat_ff;
      dim_in    = dim_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (op)
                  OP_BASE_FEATURE: begin
                     cmd.feat_wr = entry_ok && feat_elem_ok;
                  end
                  OP_BASE_PROJ: begin
                     cmd.proj_wr = entry_ok && proj_elem_ok;
                  end
                  OP_QUERY: begin
                     cmd.query_wr = feat_elem_ok;
                     if (req_last) begin
                        cmd.scan_clear = 1'b1;
                        base_in        = '0;
                        feat_in        = '0;
                        state_in       = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // One feature of one base point enters the distance pipeline per cycle.
            cmd.issue       = 1'b1;
            cmd.issue_first = (feat_ff == '0);
            cmd.issue_last  = feat_last_hit;
            if (feat_last_hit) begin
               feat_in = '0;
               if (base_last_hit) begin
                  state_in = S_DRAIN;
               end else begin
                  base_in = base_ff + 1'b1;
               end
            end else begin
               feat_in = feat_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               dim_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.proj_rd = 1'b1;
            state_in    = S_SHOW;
         end
         S_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (dim_last_hit) begin
                  state_in = S_IDLE;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign scan_base       = base_ff;
   assign scan_feat       = feat_ff;
   assign emit_dim        = dim_ff;
   assign dim_wide        = 32'(dim_ff);
   assign rsp_coord_index = dim_wide[1:0];
   assign rsp_last_result = dim_last_hit;

   // A result that is not taken keeps its coordinate number.
   a_show_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHOW && !rsp_ready) |=> (state_ff == S_SHOW && $stable(dim_ff)))
      else $error("result dropped while stalled");

   // The coordinate counter never passes the last coordinate of the answer.
   a_dim_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHOW) |-> (32'(dim_ff) <= 32'(nd_last)))
      else $error("coordinate counter out of range");

endmodule

// File: sv/nbpl_dpath.sv
`timescale 1ns / 1ps

module nbpl_dpath #(
   parameter int MAX_BASE     = nbpl_pkg::DEF_MAX_BASE,
   parameter int MAX_FEATURES = nbpl_pkg::DEF_MAX_FEATURES,
   parameter int MAX_OUT_DIMS = nbpl_pkg::DEF_MAX_OUT_DIMS,
   parameter int VALUE_WIDTH  = nbpl_pkg::DEF_VALUE_WIDTH,
   localparam int BW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1,
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
   localparam int DW = (MAX_OUT_DIMS > 1) ? $clog2(MAX_OUT_DIMS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nbpl_pkg::cmd_type           cmd,
   output nbpl_pkg::status_type        status,
   input  logic [BW-1:0]               scan_base,
   input  logic [FW-1:0]               scan_feat,
   input  logic [DW-1:0]               emit_dim,
   input  logic [7:0]                  req_entry,
   input  logic [3:0]                  req_element,
   input  logic [nbpl_pkg::DATA_WIDTH-1:0] req_value,
   output logic [7:0]                  rsp_nearest_index,
   output logic [nbpl_pkg::DATA_WIDTH-1:0] rsp_coordinate
);
   import nbpl_pkg::*;

   localparam int FEAT_DEPTH = MAX_BASE * MAX_FEATURES;
   localparam int PROJ_DEPTH = MAX_BASE * MAX_OUT_DIMS;
   localparam int FAW = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int PAW = (PROJ_DEPTH > 1) ? $clog2(PROJ_DEPTH) : 1;
   localparam int PW  = 2 * VALUE_WIDTH;

   logic [VALUE_WIDTH-1:0] feat_mem  [FEAT_DEPTH];
   logic [VALUE_WIDTH-1:0] proj_mem  [PROJ_DEPTH];
   logic [VALUE_WIDTH-1:0] query_mem [MAX_FEATURES];

   logic [31:0]            feat_wr_lin, feat_rd_lin, proj_wr_lin, proj_rd_lin, query_wr_lin;
   logic [FAW-1:0]         feat_wr_addr, feat_rd_addr;
   logic [PAW-1:0]         proj_wr_addr, proj_rd_addr;
   logic [FW-1:0]          query_wr_addr;
   logic [VALUE_WIDTH-1:0] wr_value;

   // Pipeline: read, difference, square, accumulate.
   logic                   rd_vld_ff, df_vld_ff, sq_vld_ff, ac_vld_ff;
   logic                   rd_first_ff, df_first_ff, sq_first_ff;
   logic                   rd_last_ff, df_last_ff, sq_last_ff, ac_last_ff;
   logic [BW-1:0]          rd_idx_ff, df_idx_ff, sq_idx_ff, ac_idx_ff;
   logic [VALUE_WIDTH-1:0] feat_rd_ff, query_rd_ff;
   logic [VALUE_WIDTH-1:0] abs_ff;
   logic [PW-1:0]          prod_ff;
   logic [DIST_WIDTH-1:0]  acc_ff, acc_in;
   logic [DIST_WIDTH:0]    acc_sum;
   logic [VALUE_WIDTH:0]   diff, diff_mag;
   logic [DIST_WIDTH-1:0]  best_dist_ff;
   logic [BW-1:0]          best_idx_ff;
   logic signed [VALUE_WIDTH-1:0] proj_rd_ff;
   logic [31:0]            best_wide;

   // Store addresses: row of a base point times the row length plus the element.
   always_comb begin
      feat_wr_lin  = 32'(req_entry) * 32'(MAX_FEATURES) + 32'(req_element);
      feat_rd_lin  = 32'(scan_base) * 32'(MAX_FEATURES) + 32'(scan_feat);
      proj_wr_lin  = 32'(req_entry) * 32'(MAX_OUT_DIMS) + 32'(req_element);
      proj_rd_lin  = 32'(best_idx_ff) * 32'(MAX_OUT_DIMS) + 32'(emit_dim);
      query_wr_lin = 32'(req_element);
   end

   assign feat_wr_addr  = feat_wr_lin[FAW-1:0];
   assign feat_rd_addr  = feat_rd_lin[FAW-1:0];
   assign proj_wr_addr  = proj_wr_lin[PAW-1:0];
   assign proj_rd_addr  = proj_rd_lin[PAW-1:0];
   assign query_wr_addr = query_wr_lin[FW-1:0];
   assign wr_value      = req_value[VALUE_WIDTH-1:0];

   // Base feature store: one write port, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.feat_wr) begin
         feat_mem[feat_wr_addr] <= wr_value;
      end
      if (cmd.issue) begin
         feat_rd_ff <= feat_mem[feat_rd_addr];
      end
   end

   // Query buffer, read in step with the feature store.
   always_ff @(posedge clock) begin
      if (cmd.query_wr) begin
         query_mem[query_wr_addr] <= wr_value;
      end
      if (cmd.issue) begin
         query_rd_ff <= query_mem[scan_feat];
      end
   end

   // Projection store, read once per emitted coordinate.
   always_ff @(posedge clock) begin
      if (cmd.proj_wr) begin
         proj_mem[proj_wr_addr] <= wr_value;
      end
      if (cmd.proj_rd) begin
         proj_rd_ff <= proj_mem[proj_rd_addr];
      end
   end

   // Absolute difference; it always fits in VALUE_WIDTH unsigned bits.
   always_comb begin
      diff     = {feat_rd_ff[VALUE_WIDTH-1], feat_rd_ff}
               - {query_rd_ff[VALUE_WIDTH-1], query_rd_ff};
      diff_mag = diff[VALUE_WIDTH] ? (~diff + 1'b1) : diff;
   end

   // Saturating accumulation; the first feature of a point starts a new sum.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + (DIST_WIDTH + 1)'(prod_ff);
      if (sq_first_ff) begin
         acc_in = DIST_WIDTH'(prod_ff);
      end else if (acc_sum[DIST_WIDTH]) begin
         acc_in = '1;
      end else begin
         acc_in = acc_sum[DIST_WIDTH-1:0];
      end
   end

   // Valid flags of the pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         df_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
         ac_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         df_vld_ff <= rd_vld_ff;
         sq_vld_ff <= df_vld_ff;
         ac_vld_ff <= sq_vld_ff;
      end
   end

   // Stage payload and tags.
   always_ff @(posedge clock) begin
      rd_first_ff <= cmd.issue_first;
      rd_last_ff  <= cmd.issue_last;
      rd_idx_ff   <= scan_base;
      df_first_ff <= rd_first_ff;
      df_last_ff  <= rd_last_ff;
      df_idx_ff   <= rd_idx_ff;
      abs_ff      <= diff_mag[VALUE_WIDTH-1:0];
      sq_first_ff <= df_first_ff;
      sq_last_ff  <= df_last_ff;
      sq_idx_ff   <= df_idx_ff;
      prod_ff     <= PW'(abs_ff) * PW'(abs_ff);
      ac_last_ff  <= sq_last_ff;
      ac_idx_ff   <= sq_idx_ff;
      if (sq_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Best so far: only a strictly smaller distance replaces it, so ties keep the lower index.
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clear) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (ac_vld_ff && ac_last_ff && (acc_ff < best_dist_ff)) begin
         best_dist_ff <= acc_ff;
         best_idx_ff  <= ac_idx_ff;
      end
   end

   assign status.pipe_busy  = rd_vld_ff || df_vld_ff || sq_vld_ff || ac_vld_ff;
   assign best_wide         = 32'(best_idx_ff);
   assign rsp_nearest_index = best_wide[7:0];
   assign rsp_coordinate    = DATA_WIDTH'(proj_rd_ff);

   // The best distance only falls while results leave the pipeline.
   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      (ac_vld_ff && !cmd.scan_clear) |=> (best_dist_ff <= $past(best_dist_ff)))
      else $error("best distance grew during a scan");

   // The answer is read only once the distance pipeline has emptied.
   a_read_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.proj_rd |-> !(rd_vld_ff || df_vld_ff || sq_vld_ff || ac_vld_ff))
      else $error("projection read before scan finished");

endmodule

// File: sv/nearest_base_projection_lookup_top.sv
// Nearest base point lookup: base points are loaded one feature or one projection
// coordinate per input transfer (operation 0 or 1), and a query is loaded one feature
// per transfer (operation 2). The query feature marked last starts a scan of base points
// 0 to base_count-1; one squared feature difference is formed per cycle by a single
// subtract, multiply and saturating accumulate pipeline, which is then left to drain.
// The answer is the lowest index at the least distance, and its out_dims projection
// coordinates follow as separate results, each read from the projection store and then
// shown until the result side takes it. The block takes no new input transfer from the
// start of a scan until its last result has been taken. Stores come up holding unknown
// data, so every base point and query feature that is used must be written first.
// Registers at byte addresses 0, 4 and 8: base_count, feature_count, out_dims; write
// them only while no query is in progress.
`timescale 1ns / 1ps

module nearest_base_projection_lookup_top #(
   parameter int MAX_BASE     = nbpl_pkg::DEF_MAX_BASE,
   parameter int MAX_FEATURES = nbpl_pkg::DEF_MAX_FEATURES,
   parameter int MAX_OUT_DIMS = nbpl_pkg::DEF_MAX_OUT_DIMS,
   parameter int VALUE_WIDTH  = nbpl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_entry,
   input  logic [3:0]                      req_element,
   input  logic [nbpl_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                            req_last,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_nearest_index,
   output logic [nbpl_pkg::DATA_WIDTH-1:0] rsp_coordinate,
   output logic [1:0]                      rsp_coord_index,
   output logic                            rsp_last_result,
   // Register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [3:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import nbpl_pkg::*;

   localparam int BW = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int DW = (MAX_OUT_DIMS > 1) ? $clog2(MAX_OUT_DIMS) : 1;

   localparam logic [1:0] REG_BASE_COUNT    = 2'd0;
   localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
   localparam logic [1:0] REG_OUT_DIMS      = 2'd2;

   logic [8:0]    base_count_ff;
   logic [4:0]    feature_count_ff;
   logic [2:0]    out_dims_ff;
   logic          csr_wr;
   logic [1:0]    csr_index;
   cmd_type       cmd;
   status_type    status;
   logic [BW-1:0] scan_base;
   logic [FW-1:0] scan_feat;
   logic [DW-1:0] emit_dim;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Register writes complete in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_count_ff    <= 9'd1;
         feature_count_ff <= 5'd1;
         out_dims_ff      <= 3'd2;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_BASE_COUNT:    base_count_ff    <= csr_pwdata[8:0];
            REG_FEATURE_COUNT: feature_count_ff <= csr_pwdata[4:0];
            REG_OUT_DIMS:      out_dims_ff      <= csr_pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_BASE_COUNT:    csr_prdata = 32'(base_count_ff);
         REG_FEATURE_COUNT: csr_prdata = 32'(feature_count_ff);
         REG_OUT_DIMS:      csr_prdata = 32'(out_dims_ff);
         default:           csr_prdata = '0;
      endcase
   end

   nbpl_ctrl #(
      .MAX_BASE     (MAX_BASE),
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_OUT_DIMS (MAX_OUT_DIMS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_entry       (req_entry),
      .req_element     (req_element),
      .req_last        (req_last),
      .base_count      (base_count_ff),
      .feature_count   (feature_count_ff),
      .out_dims        (out_dims_ff),
      .cmd             (cmd),
      .status          (status),
      .scan_base       (scan_base),
      .scan_feat       (scan_feat),
      .emit_dim        (emit_dim),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coord_index (rsp_coord_index),
      .rsp_last_result (rsp_last_result)
   );

   nbpl_dpath #(
      .MAX_BASE     (MAX_BASE),
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_OUT_DIMS (MAX_OUT_DIMS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .scan_base         (scan_base),
      .scan_feat         (scan_feat),
      .emit_dim          (emit_dim),
      .req_entry         (req_entry),
      .req_element       (req_element),
      .req_value         (req_value),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_coordinate    (rsp_coordinate)
   );

endmodule
